// ===== design/bcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Binary command deframer package
// Shared constants and types for the deframer and its table lookup.
// ----------------------------------------------------------------------------
package bcd_pkg;

	localparam logic [7:0] HDR_FIRST  = 8'hCC;
	localparam logic [7:0] HDR_SECOND = 8'h44;

	localparam int CfgDataW = 16;

	// Register index of the entry count; table entry k sits at index k + 1.
	localparam int CFG_ENTRY_COUNT = 0;

	typedef enum logic [3:0] {
		PH_HUNT    = 4'd0,
		PH_SECOND  = 4'd1,
		PH_MODULE  = 4'd2,
		PH_COMMAND = 4'd3,
		PH_STATUS  = 4'd4,
		PH_LEN_HI  = 4'd5,
		PH_LEN_LO  = 4'd6,
		PH_CHK_HI  = 4'd7,
		PH_CHK_LO  = 4'd8,
		PH_DATA    = 4'd9
	} phase_t;

	typedef enum logic {
		KIND_HEADER = 1'b0,
		KIND_DATA   = 1'b1
	} kind_t;

	typedef struct packed {
		logic       module_known;
		logic       command_known;
		logic [1:0] slot;
	} match_t;

endpackage

// ===== design/bcd_in_if.sv =====
// ----------------------------------------------------------------------------
// Deframer input channel
// Valid/ready channel that carries one received byte per request.
// ----------------------------------------------------------------------------
interface bcd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== design/bcd_out_if.sv =====
// ----------------------------------------------------------------------------
// Deframer result channel
// Valid/ready channel that carries one header or payload result per request.
// ----------------------------------------------------------------------------
interface bcd_out_if;
	logic        valid;
	logic        ready;
	logic        item_kind;
	logic [7:0]  module_id;
	logic [7:0]  command_id;
	logic [7:0]  status_byte;
	logic [15:0] payload_length;
	logic [15:0] check_word;
	logic        module_known;
	logic        command_known;
	logic [1:0]  match_slot;
	logic [7:0]  payload_byte;
	logic        end_of_packet;

	modport source (
		output valid, input ready,
		output item_kind, output module_id, output command_id, output status_byte,
		output payload_length, output check_word, output module_known,
		output command_known, output match_slot, output payload_byte,
		output end_of_packet
	);
	modport sink (
		input valid, output ready,
		input item_kind, input module_id, input command_id, input status_byte,
		input payload_length, input check_word, input module_known,
		input command_known, input match_slot, input payload_byte,
		input end_of_packet
	);
endinterface

// ===== design/bcd_match.sv =====
// ----------------------------------------------------------------------------
// Command table lookup
// Compares module and command bytes against the searched table entries and
// returns the module hit, the full hit and the first fully matching slot.
// ----------------------------------------------------------------------------
module bcd_match #(
	parameter int TABLE_ENTRIES = 4
) (
	input  logic [15:0]      entries [TABLE_ENTRIES],
	input  logic [2:0]       entry_count,
	input  logic [7:0]       module_id,
	input  logic [7:0]       command_id,
	output bcd_pkg::match_t  result
);
	import bcd_pkg::*;

	logic [TABLE_ENTRIES-1:0] mod_hit;
	logic [TABLE_ENTRIES-1:0] full_hit;

	always_comb begin
		for (int k = 0; k < TABLE_ENTRIES; k++) begin
			mod_hit[k]  = (int'(entry_count) > k) && (entries[k][15:8] == module_id);
			full_hit[k] = mod_hit[k] && (entries[k][7:0] == command_id);
		end
	end

	// Scanning from the top down leaves the lowest matching entry in place.
	always_comb begin
		result.module_known  = |mod_hit;
		result.command_known = |full_hit;
		result.slot          = 2'd0;
		for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
			if (full_hit[k]) begin
				result.slot = 2'(k);
			end
		end
	end

endmodule

// ===== design/binary_command_deframer_top.sv =====
// ----------------------------------------------------------------------------
// Binary command deframer
// Hunts for the 0xCC 0x44 header in a byte stream, captures the packet header,
// looks the module and command up in a small table and emits one header
// result followed by one result per payload byte.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload                               Handshake
//  rx       in         rx_byte                               valid / ready
//  res      out        header or payload result fields       valid / ready
//  cfg      in         cfg_index, cfg_data                   cfg_we only
//
// Every received byte passes through the input stage and, if it produces a
// result, through the result register, so a request can be accepted in
// every cycle unless the input stage waits as described below.
// The input stage only waits when it holds a byte that produces a result and
// the result register is still full and not being taken; bytes that produce
// no result always move on. arst_n clears the parser, the held header bytes
// and the configuration registers; no clearing pass is needed.
// ----------------------------------------------------------------------------
module binary_command_deframer_top #(
	parameter  int TABLE_ENTRIES = 4,
	localparam int CfgIdxW = $clog2(TABLE_ENTRIES + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	bcd_in_if.sink                        rx,
	bcd_out_if.source                     res,
	input  logic                          cfg_we,
	input  logic [CfgIdxW-1:0]            cfg_index,
	input  logic [bcd_pkg::CfgDataW-1:0]  cfg_data
);
	import bcd_pkg::*;

	// Configuration registers. Writes to indexes past the table are dropped.
	logic [2:0]  entry_count_q;
	logic [15:0] entry_q [TABLE_ENTRIES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= 3'd0;
			for (int k = 0; k < TABLE_ENTRIES; k++) begin
				entry_q[k] <= 16'd0;
			end
		end else if (cfg_we) begin
			if (cfg_index == CfgIdxW'(CFG_ENTRY_COUNT)) begin
				entry_count_q <= cfg_data[2:0];
			end
			for (int k = 0; k < TABLE_ENTRIES; k++) begin
				if (cfg_index == CfgIdxW'(k + 1)) begin
					entry_q[k] <= cfg_data[15:0];
				end
			end
		end
	end

	// Input stage: the accepted byte waits here while the parser works on it.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Result register.
	logic        res_valid_q;
	logic        kind_q;
	logic [7:0]  module_id_q;
	logic [7:0]  command_id_q;
	logic [7:0]  status_q;
	logic [15:0] length_out_q;
	logic [15:0] check_q;
	logic        module_known_q;
	logic        command_known_q;
	logic [1:0]  slot_q;
	logic [7:0]  payload_q;
	logic        eop_q;

	// Parser state.
	phase_t      phase_q;
	phase_t      phase_next;
	logic [7:0]  module_hold_q;
	logic [7:0]  command_hold_q;
	logic [7:0]  status_hold_q;
	logic [15:0] length_hold_q;
	logic [7:0]  check_high_q;
	logic [15:0] remaining_q;

	logic        emits;
	logic        res_free;
	logic        advance;
	logic [15:0] remaining_dec;
	match_t      lookup;

	bcd_match #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_match (
		.entries     (entry_q),
		.entry_count (entry_count_q),
		.module_id   (module_hold_q),
		.command_id  (command_hold_q),
		.result      (lookup)
	);

	assign remaining_dec = remaining_q - 16'd1;

	// Only the last check byte and payload bytes produce a result.
	always_comb begin
		emits = 1'b0;
		unique case (phase_q)
			PH_CHK_LO, PH_DATA: emits = 1'b1;
			default:            emits = 1'b0;
		endcase
	end

	assign res_free = !res_valid_q || res.ready;
	assign advance  = valid_s1 && (!emits || res_free);
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// Next phase. A byte that breaks the header is looked at again as a
	// possible first header byte.
	always_comb begin
		phase_next = phase_q;
		unique case (phase_q)
			PH_SECOND: begin
				if (byte_s1 == HDR_SECOND) begin
					phase_next = PH_MODULE;
				end else if (byte_s1 == HDR_FIRST) begin
					phase_next = PH_SECOND;
				end else begin
					phase_next = PH_HUNT;
				end
			end
			PH_MODULE:  phase_next = PH_COMMAND;
			PH_COMMAND: phase_next = PH_STATUS;
			PH_STATUS:  phase_next = PH_LEN_HI;
			PH_LEN_HI:  phase_next = PH_LEN_LO;
			PH_LEN_LO:  phase_next = PH_CHK_HI;
			PH_CHK_HI:  phase_next = PH_CHK_LO;
			PH_CHK_LO:  phase_next = (remaining_q == 16'd0) ? PH_HUNT : PH_DATA;
			PH_DATA:    phase_next = (remaining_dec == 16'd0) ? PH_HUNT : PH_DATA;
			default:    phase_next = (byte_s1 == HDR_FIRST) ? PH_SECOND : PH_HUNT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HUNT;
			module_hold_q  <= 8'd0;
			command_hold_q <= 8'd0;
			status_hold_q  <= 8'd0;
			length_hold_q  <= 16'd0;
			check_high_q   <= 8'd0;
			remaining_q    <= 16'd0;
		end else if (advance) begin
			phase_q <= phase_next;
			case (phase_q)
				PH_MODULE:  module_hold_q  <= byte_s1;
				PH_COMMAND: command_hold_q <= byte_s1;
				PH_STATUS:  status_hold_q  <= byte_s1;
				PH_LEN_HI:  length_hold_q  <= {byte_s1, 8'd0};
				PH_LEN_LO: begin
					length_hold_q <= {length_hold_q[15:8], byte_s1};
					remaining_q   <= {length_hold_q[15:8], byte_s1};
				end
				PH_CHK_HI:  check_high_q   <= byte_s1;
				PH_DATA:    remaining_q    <= remaining_dec;
				default: ;
			endcase
		end
	end

	// Result register. The header result carries the lookup and check word;
	// payload result repeats the held header bytes and zeros check and lookup.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_free) begin
			res_valid_q <= advance && emits;
		end
	end

	always_ff @(posedge clk) begin
		if (res_free && advance && emits) begin
			module_id_q  <= module_hold_q;
			command_id_q <= command_hold_q;
			status_q     <= status_hold_q;
			length_out_q <= length_hold_q;
			if (phase_q == PH_CHK_LO) begin
				kind_q          <= KIND_HEADER;
				check_q         <= {check_high_q, byte_s1};
				module_known_q  <= lookup.module_known;
				command_known_q <= lookup.command_known;
				slot_q          <= lookup.slot;
				payload_q       <= 8'd0;
				eop_q           <= (remaining_q == 16'd0);
			end else begin
				kind_q          <= KIND_DATA;
				check_q         <= 16'd0;
				module_known_q  <= 1'b0;
				command_known_q <= 1'b0;
				slot_q          <= 2'd0;
				payload_q       <= byte_s1;
				eop_q           <= (remaining_dec == 16'd0);
			end
		end
	end

	assign res.valid          = res_valid_q;
	assign res.item_kind      = kind_q;
	assign res.module_id      = module_id_q;
	assign res.command_id     = command_id_q;
	assign res.status_byte    = status_q;
	assign res.payload_length = length_out_q;
	assign res.check_word     = check_q;
	assign res.module_known   = module_known_q;
	assign res.command_known  = command_known_q;
	assign res.match_slot     = slot_q;
	assign res.payload_byte   = payload_q;
	assign res.end_of_packet  = eop_q;

endmodule
